[rtl/efreq_pkg.sv]
package efreq_pkg;

  localparam int COUNTER_WIDTH_DEF = 64;
  localparam int TICK_WIDTH_DEF    = 32;

  localparam int CNT_FIELD_W  = 64;
  localparam int TICK_FIELD_W = 32;
  localparam int FREQ_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int BASE_W       = 16;

  localparam int NOM_W  = 26;
  localparam int PART_W = NOM_W + 32;
  localparam int PROD_W = NOM_W + CNT_FIELD_W;

  localparam logic [NOM_W-1:0] KHZ_PER_MHZ = NOM_W'(1000);

  localparam int DIV_STEPS = FREQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_BASE_MHZ = 1'b0,
    REG_FEATURE  = 1'b1
  } efreq_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_HW_ERROR    = 2'd2
  } efreq_status_e;

  typedef enum logic [2:0] {
    CLS_UNSUP,
    CLS_FAIL,
    CLS_BASE,
    CLS_DECR,
    CLS_CALC
  } efreq_class_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_DECIDE,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_FIN
  } efreq_state_e;

  typedef struct packed {
    logic [CNT_FIELD_W-1:0]  actual_cycles;
    logic [CNT_FIELD_W-1:0]  reference_cycles;
    logic [TICK_FIELD_W-1:0] tick_stamp;
    logic                    read_failed;
  } efreq_in_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq_khz;
    logic [STATUS_W-1:0] status;
  } efreq_out_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_init;
    logic div_step;
    logic commit;
  } efreq_cmd_t;

  typedef struct packed {
    efreq_class_e cls;
    logic         sat;
  } efreq_stat_t;

endpackage

[rtl/efreq_dp.sv]
module efreq_dp #(
  parameter int COUNTER_WIDTH = efreq_pkg::COUNTER_WIDTH_DEF,
  parameter int TICK_WIDTH    = efreq_pkg::TICK_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  efreq_pkg::efreq_cmd_t             cmd_i,
  output efreq_pkg::efreq_stat_t            stat_o,
  input  logic [efreq_pkg::BASE_W-1:0]      base_mhz_i,
  input  logic                              feature_i,
  input  efreq_pkg::efreq_in_t              in_data_i,
  output efreq_pkg::efreq_out_t             out_data_o
);
  import efreq_pkg::*;

  localparam int CW = COUNTER_WIDTH;
  localparam int TW = (TICK_WIDTH < TICK_FIELD_W) ? TICK_WIDTH : TICK_FIELD_W;

  logic [CW-1:0]     act_q, ref_q, prev_act_q, prev_ref_q;
  logic [TW-1:0]     tick_q, prev_tick_q;
  logic              failed_q;
  logic [CW-1:0]     dact_q, dref_q;
  logic [NOM_W-1:0]  nom_q;
  efreq_class_e      cls_q, cls_d;
  logic [PART_W-1:0] p0_q, p1_q;
  logic [PROD_W-1:0] prod_q;
  logic              sat_q;
  logic [CW:0]       rem_q;
  logic [FREQ_W-1:0] low_q;
  efreq_out_t        out_q;

  logic [CW:0]             da, dr, rs, rs_sub;
  logic [CNT_FIELD_W-1:0]  dpad;
  logic [PROD_W-FREQ_W-1:0] hi_part;
  logic                    ge;
  logic                    upd;

  assign da      = {1'b0, act_q} - {1'b0, prev_act_q};
  assign dr      = {1'b0, ref_q} - {1'b0, prev_ref_q};
  assign dpad    = CNT_FIELD_W'(dact_q);
  assign hi_part = prod_q[PROD_W-1:FREQ_W];
  assign rs      = {rem_q[CW-1:0], low_q[FREQ_W-1]};
  assign rs_sub  = rs - {1'b0, dref_q};
  assign ge      = (rs >= {1'b0, dref_q});
  assign upd     = cmd_i.commit && (cls_q == CLS_BASE || cls_q == CLS_CALC);

  always_comb begin
    if (!feature_i || base_mhz_i == '0) begin
      cls_d = CLS_UNSUP;
    end else if (failed_q) begin
      cls_d = CLS_FAIL;
    end else if (prev_tick_q == '0 || ref_q == prev_ref_q || tick_q == prev_tick_q) begin
      cls_d = CLS_BASE;
    end else if (da[CW] || dr[CW]) begin
      cls_d = CLS_DECR;
    end else begin
      cls_d = CLS_CALC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_act_q  <= '0;
      prev_ref_q  <= '0;
      prev_tick_q <= '0;
      cls_q       <= CLS_UNSUP;
    end else begin
      if (cmd_i.classify) begin
        cls_q <= cls_d;
      end
      if (upd) begin
        prev_act_q  <= act_q;
        prev_ref_q  <= ref_q;
        prev_tick_q <= tick_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= in_data_i.actual_cycles[CW-1:0];
      ref_q    <= in_data_i.reference_cycles[CW-1:0];
      tick_q   <= in_data_i.tick_stamp[TW-1:0];
      failed_q <= in_data_i.read_failed;
    end
    if (cmd_i.classify) begin
      dact_q <= da[CW-1:0];
      dref_q <= dr[CW-1:0];
      nom_q  <= {{(NOM_W-BASE_W){1'b0}}, base_mhz_i} * KHZ_PER_MHZ;
    end
    if (cmd_i.mul_lo) begin
      p0_q <= PART_W'(nom_q) * PART_W'(dpad[31:0]);
    end
    if (cmd_i.mul_hi) begin
      p1_q <= PART_W'(nom_q) * PART_W'(dpad[CNT_FIELD_W-1:32]);
    end
    if (cmd_i.sum) begin
      prod_q <= PROD_W'(p0_q) + {p1_q, 32'd0};
    end
    if (cmd_i.div_init) begin
      sat_q <= (CNT_FIELD_W'(hi_part) >= CNT_FIELD_W'(dref_q));
      rem_q <= (CW+1)'(hi_part);
      low_q <= prod_q[FREQ_W-1:0];
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rs_sub;
      end else begin
        rem_q <= rs;
      end
      low_q <= {low_q[FREQ_W-2:0], ge};
    end
    if (cmd_i.commit) begin
      case (cls_q)
        CLS_UNSUP: begin
          out_q.freq_khz <= '0;
          out_q.status   <= ST_UNSUPPORTED;
        end
        CLS_BASE: begin
          out_q.freq_khz <= FREQ_W'(nom_q);
          out_q.status   <= ST_OK;
        end
        CLS_CALC: begin
          out_q.freq_khz <= sat_q ? '1 : low_q;
          out_q.status   <= ST_OK;
        end
        default: begin
          out_q.freq_khz <= '0;
          out_q.status   <= ST_HW_ERROR;
        end
      endcase
    end
  end

  assign stat_o.cls = cls_q;
  assign stat_o.sat = sat_q;
  assign out_data_o = out_q;

endmodule

[rtl/efreq_ctrl.sv]
module efreq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output efreq_pkg::efreq_cmd_t  cmd_o,
  input  efreq_pkg::efreq_stat_t stat_i
);
  import efreq_pkg::*;

  efreq_state_e      state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = (stat_i.cls == CLS_CALC) ? S_MUL_LO : S_FIN;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (stat_i.sat) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DIV) |-> (cnt_q == '0))
    else $error("step counter not clear outside divide");

  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside finish");

  a_accept_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLASS))
    else $error("accepted beat not classified next");

  a_mul_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_LO) |-> (stat_i.cls == CLS_CALC))
    else $error("multiply entered for special case");

endmodule

[rtl/effective_frequency_from_counter_deltas.sv]
// Sequence: capture, classify, decide, then finish for unsupported, error and
// baseline samples; a computed frequency adds two partial multiplies, a sum,
// divider setup and the one-bit-per-cycle restoring divider (skipped when the
// quotient saturates). A new sample is taken only after the last one commits.
// Reset: async active low; clears config, FSM, class, previous counters, tick.
module effective_frequency_from_counter_deltas #(
  parameter int COUNTER_WIDTH = efreq_pkg::COUNTER_WIDTH_DEF,
  parameter int TICK_WIDTH    = efreq_pkg::TICK_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [efreq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [efreq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [efreq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  efreq_pkg::efreq_in_t              in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output efreq_pkg::efreq_out_t             out_data_o
);
  import efreq_pkg::*;

  logic [BASE_W-1:0] base_mhz_q;
  logic              feature_q;
  efreq_reg_e        reg_idx;
  logic              wr_en;
  efreq_cmd_t        cmd;
  efreq_stat_t       stat;

  assign pready  = 1'b1;
  assign reg_idx = efreq_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mhz_q <= '0;
      feature_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_MHZ: base_mhz_q <= pwdata[BASE_W-1:0];
        REG_FEATURE:  feature_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_MHZ: prdata = APB_DATA_W'(base_mhz_q);
      REG_FEATURE:  prdata = APB_DATA_W'(feature_q);
      default:      prdata = '0;
    endcase
  end

  efreq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  efreq_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .TICK_WIDTH    (TICK_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .base_mhz_i (base_mhz_q),
    .feature_i  (feature_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
